// ===== rtl/core/lbse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbse_pkg: shared types and constants of the leaky bucket shaper
// Time widths, queue sizing, verdict and register codes, and the queue entry
// that carries a classified packet from the front part to the back part.
// ----------------------------------------------------------------------------
package lbse_pkg;

	// timestamp and fixed point layout
	localparam int TIME_BITS      = 48;
	localparam int FRAC_BITS      = 16;
	localparam int Q16_W          = 64;
	localparam int LIM_W          = TIME_BITS + 1;
	localparam int CMP_W          = Q16_W + 1;

	// serialization product
	localparam int OVERHEAD_BYTES = 24;
	localparam int LEN_W          = 14;
	localparam int LEN_OH_W       = LEN_W + 1;
	localparam int TPB_W          = 32;
	localparam int PROD_W         = LEN_OH_W + TPB_W;

	// queue between front and back
	localparam int FIFO_AW        = 2;
	localparam int FIFO_DEPTH     = 2 ** FIFO_AW;
	localparam int FIFO_CW        = FIFO_AW + 1;

	// packet header codes
	localparam logic [1:0] IP_KIND_NOT_IP = 2'd2;
	localparam logic [1:0] ECN_NOT_ECT    = 2'd0;
	localparam logic [1:0] ECN_CE         = 2'd3;

	typedef enum logic [1:0] {
		VERDICT_FORWARD = 2'd0,
		VERDICT_BACKLOG = 2'd1,
		VERDICT_NOT_ECT = 2'd2,
		VERDICT_LOSS    = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		CFG_DELAY    = 3'd0,
		CFG_TPB      = 3'd1,
		CFG_BOUND    = 3'd2,
		CFG_ECN_THR  = 3'd3,
		CFG_LOSS_THR = 3'd4
	} cfg_index_t;

	// one classified packet, all limits precomputed against its nominal time
	typedef struct packed {
		logic [TIME_BITS-1:0] send;           // nominal send tick
		logic [LIM_W-1:0]     lim_bound;      // send + backlog bound, ticks
		logic [LIM_W-1:0]     lim_ecn;        // send + ecn threshold, ticks
		logic [Q16_W-1:0]     send_plus_prod; // saturated send_q16 + serialization
		logic [PROD_W-1:0]    prod;           // serialization time, q16
		logic                 loss;           // draw below loss threshold
		logic                 ect;            // ip and ecn capable
		logic                 mark;           // capable and not already ce
	} lbse_entry_t;

endpackage

// ===== rtl/core/lbse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbse_front: packet intake and classification
// Two stages: nominal time, serialization product and header flags first,
// then the limit sums that let the back part decide with plain compares.
// ----------------------------------------------------------------------------
module lbse_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [47:0]                    arrival_time,
	input  logic [lbse_pkg::LEN_W-1:0]     packet_length,
	input  logic [1:0]                     ip_kind,
	input  logic [1:0]                     ecn_bits,
	input  logic [63:0]                    loss_draw,
	input  logic [31:0]                    delay_ticks,
	input  logic [lbse_pkg::TPB_W-1:0]     ticks_per_byte_q16,
	input  logic [31:0]                    backlog_bound_ticks,
	input  logic [31:0]                    ecn_threshold_ticks,
	input  logic [63:0]                    loss_threshold,
	input  logic [lbse_pkg::FIFO_CW-1:0]   fifo_count,
	output logic                           push,
	output lbse_pkg::lbse_entry_t          push_entry
);

	logic                               accept;
	logic [lbse_pkg::FIFO_CW:0]         occupancy;
	logic [lbse_pkg::LEN_OH_W-1:0]      len_oh;
	logic [lbse_pkg::Q16_W-1:0]         send_q16;
	logic [lbse_pkg::CMP_W-1:0]         sp_sum;

	logic                               v_s1;
	logic [lbse_pkg::TIME_BITS-1:0]     send_s1;
	logic [lbse_pkg::PROD_W-1:0]        prod_s1;
	logic                               loss_s1;
	logic                               ect_s1;
	logic                               mark_s1;

	logic                               v_s2;
	lbse_pkg::lbse_entry_t              entry_s2;

	// credit check: queue entries plus items still in the two stages
	always_comb begin
		occupancy = (lbse_pkg::FIFO_CW+1)'(fifo_count)
			+ (lbse_pkg::FIFO_CW+1)'(v_s1) + (lbse_pkg::FIFO_CW+1)'(v_s2);
	end
	assign in_stall = occupancy >= (lbse_pkg::FIFO_CW+1)'(lbse_pkg::FIFO_DEPTH);
	assign accept   = in_valid && !in_stall;

	assign len_oh = lbse_pkg::LEN_OH_W'(packet_length)
		+ lbse_pkg::LEN_OH_W'(lbse_pkg::OVERHEAD_BYTES);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// stage 1 payload: nominal time, product, flags
	always_ff @(posedge clk) begin
		if (accept) begin
			send_s1 <= lbse_pkg::TIME_BITS'(arrival_time[lbse_pkg::TIME_BITS-1:0]
				+ lbse_pkg::TIME_BITS'(delay_ticks));
			prod_s1 <= lbse_pkg::PROD_W'(len_oh) * lbse_pkg::PROD_W'(ticks_per_byte_q16);
			loss_s1 <= loss_draw < loss_threshold;
			ect_s1  <= (ip_kind < lbse_pkg::IP_KIND_NOT_IP)
				&& (ecn_bits != lbse_pkg::ECN_NOT_ECT);
			mark_s1 <= (ip_kind < lbse_pkg::IP_KIND_NOT_IP)
				&& (ecn_bits != lbse_pkg::ECN_NOT_ECT) && (ecn_bits != lbse_pkg::ECN_CE);
		end
	end

	// saturated earliest time after this packet if the link is idle
	assign send_q16 = lbse_pkg::Q16_W'({send_s1, {lbse_pkg::FRAC_BITS{1'b0}}});
	assign sp_sum   = {1'b0, send_q16} + lbse_pkg::CMP_W'(prod_s1);

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload: limit sums
	always_ff @(posedge clk) begin
		if (v_s1) begin
			entry_s2.send      <= send_s1;
			entry_s2.lim_bound <= lbse_pkg::LIM_W'(send_s1)
				+ lbse_pkg::LIM_W'(backlog_bound_ticks);
			entry_s2.lim_ecn   <= lbse_pkg::LIM_W'(send_s1)
				+ lbse_pkg::LIM_W'(ecn_threshold_ticks);
			entry_s2.send_plus_prod <= sp_sum[lbse_pkg::Q16_W] ? '1
				: sp_sum[lbse_pkg::Q16_W-1:0];
			entry_s2.prod      <= prod_s1;
			entry_s2.loss      <= loss_s1;
			entry_s2.ect       <= ect_s1;
			entry_s2.mark      <= mark_s1;
		end
	end

	assign push       = v_s2;
	assign push_entry = entry_s2;

endmodule

// ===== rtl/core/lbse_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbse_fifo: short queue of classified packets
// Register based ring with a fill count; head entry is read in place.
// ----------------------------------------------------------------------------
module lbse_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lbse_pkg::lbse_entry_t        push_entry,
	input  logic                         pop,
	output lbse_pkg::lbse_entry_t        head_entry,
	output logic                         empty,
	output logic [lbse_pkg::FIFO_CW-1:0] count
);

	lbse_pkg::lbse_entry_t               mem_q [lbse_pkg::FIFO_DEPTH];
	logic [lbse_pkg::FIFO_AW-1:0]        wr_ptr_q;
	logic [lbse_pkg::FIFO_AW-1:0]        rd_ptr_q;
	logic [lbse_pkg::FIFO_CW-1:0]        count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head_entry = mem_q[rd_ptr_q];
	assign empty      = (count_q == '0);
	assign count      = count_q;

	// front credit check must keep the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < lbse_pkg::FIFO_CW'(lbse_pkg::FIFO_DEPTH)) || pop)
		else $error("lbse_fifo: push into full queue");

	// pointer distance agrees with the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != lbse_pkg::FIFO_CW'(lbse_pkg::FIFO_DEPTH))
			|-> (lbse_pkg::FIFO_AW'(wr_ptr_q - rd_ptr_q) == lbse_pkg::FIFO_AW'(count_q)))
		else $error("lbse_fifo: pointers and count disagree");

endmodule

// ===== rtl/core/lbse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbse_back: scheduling against the link's next free time
// Compares the stored next-free time with the precomputed limits, picks the
// verdict, advances the next-free time and registers the result item.
// ----------------------------------------------------------------------------
module lbse_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lbse_pkg::lbse_entry_t          head_entry,
	input  logic                           fifo_empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     verdict,
	output logic                           mark_ce,
	output logic [47:0]                    depart_time
);

	logic [lbse_pkg::Q16_W-1:0]     next_free_q;
	logic                           out_valid_q;
	lbse_pkg::verdict_t             verdict_q;
	logic                           mark_q;
	logic [47:0]                    depart_time_q;

	logic [lbse_pkg::Q16_W-1:0]     send_q16;
	logic                           sched_is_nf;
	logic                           over_bound;
	logic                           over_ecn;
	logic                           not_ect_drop;
	logic                           keep;
	logic [lbse_pkg::CMP_W-1:0]     nf_sum;
	logic [lbse_pkg::Q16_W-1:0]     nf_advanced;
	logic [lbse_pkg::TIME_BITS-1:0] sched_ticks;
	lbse_pkg::verdict_t             verdict_d;

	// take the head whenever the output register is free or draining
	assign pop = !fifo_empty && (!out_valid_q || !out_stall);

	// compares of next-free against nominal time and limits, all in parallel
	always_comb begin
		send_q16 = lbse_pkg::Q16_W'({head_entry.send, {lbse_pkg::FRAC_BITS{1'b0}}});
		sched_is_nf = next_free_q > send_q16;
		over_bound = {1'b0, next_free_q}
			> lbse_pkg::CMP_W'({head_entry.lim_bound, {lbse_pkg::FRAC_BITS{1'b0}}});
		over_ecn = {1'b0, next_free_q}
			> lbse_pkg::CMP_W'({head_entry.lim_ecn, {lbse_pkg::FRAC_BITS{1'b0}}});
		not_ect_drop = over_ecn && !head_entry.ect;
		keep = !over_bound && !not_ect_drop;
		nf_sum = {1'b0, next_free_q} + lbse_pkg::CMP_W'(head_entry.prod);
		nf_advanced = nf_sum[lbse_pkg::Q16_W] ? '1 : nf_sum[lbse_pkg::Q16_W-1:0];
		sched_ticks = sched_is_nf
			? next_free_q[lbse_pkg::FRAC_BITS +: lbse_pkg::TIME_BITS] : head_entry.send;
		if (over_bound) begin
			verdict_d = lbse_pkg::VERDICT_BACKLOG;
		end else if (not_ect_drop) begin
			verdict_d = lbse_pkg::VERDICT_NOT_ECT;
		end else if (head_entry.loss) begin
			verdict_d = lbse_pkg::VERDICT_LOSS;
		end else begin
			verdict_d = lbse_pkg::VERDICT_FORWARD;
		end
	end

	// link state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && keep) begin
				next_free_q <= sched_is_nf ? nf_advanced : head_entry.send_plus_prod;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result item register
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_d;
			if (verdict_d == lbse_pkg::VERDICT_FORWARD) begin
				mark_q        <= over_ecn && head_entry.mark;
				depart_time_q <= 48'(sched_ticks);
			end else begin
				mark_q        <= 1'b0;
				depart_time_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign mark_ce     = mark_q;
	assign depart_time = depart_time_q;

	// the link's next free time never moves backward
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> next_free_q >= $past(next_free_q))
		else $error("lbse_back: next free time decreased");

	// dropped items carry no mark and no send time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (verdict_q != lbse_pkg::VERDICT_FORWARD)
			|-> !mark_q && (depart_time_q == '0))
		else $error("lbse_back: dropped item with payload");

	// a drop for backlog or ecn leaves the link state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !keep |=> $stable(next_free_q))
		else $error("lbse_back: dropped item advanced next free time");

endmodule

// ===== rtl/core/leaky_bucket_shaper_ecn.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_bucket_shaper_ecn: leaky bucket traffic shaper with ECN marking
// Schedules each packet against the link's next free time, drops or CE-marks
// on backlog, applies random loss, and reports verdict and send time.
// ----------------------------------------------------------------------------
// One packet in, one result out, at up to one item per clock when nothing
// stalls. An item passes two front stages (nominal send time, serialization
// product, limit sums), a four-entry queue and the back stage's output
// register. The throughput is set by the back stage's update of the 64-bit
// next-free time, which every item reads and writes. in_stall rises only when
// the queue and the front stages together hold four items. Configuration
// writes are always taken (cfg_ready is tied high) and must be made while no
// item is in flight.
// ----------------------------------------------------------------------------
module leaky_bucket_shaper_ecn (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [47:0] arrival_time,
	input  logic [13:0] packet_length,
	input  logic [1:0]  ip_kind,
	input  logic [1:0]  ecn_bits,
	input  logic [63:0] loss_draw,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic        mark_ce,
	output logic [47:0] depart_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [31:0]                    delay_ticks_q;
	logic [31:0]                    tpb_q;
	logic [31:0]                    bound_q;
	logic [31:0]                    ecn_thr_q;
	logic [63:0]                    loss_thr_q;

	logic                           push;
	lbse_pkg::lbse_entry_t          push_entry;
	logic                           pop;
	lbse_pkg::lbse_entry_t          head_entry;
	logic                           fifo_empty;
	logic [lbse_pkg::FIFO_CW-1:0]   fifo_count;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= 32'd0;
			tpb_q         <= 32'd65536;
			bound_q       <= 32'hFFFF_FFFF;
			ecn_thr_q     <= 32'hFFFF_FFFF;
			loss_thr_q    <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lbse_pkg::CFG_DELAY: begin
					delay_ticks_q <= cfg_data[31:0];
				end
				lbse_pkg::CFG_TPB: begin
					tpb_q <= cfg_data[31:0];
				end
				lbse_pkg::CFG_BOUND: begin
					bound_q <= cfg_data[31:0];
				end
				lbse_pkg::CFG_ECN_THR: begin
					ecn_thr_q <= cfg_data[31:0];
				end
				lbse_pkg::CFG_LOSS_THR: begin
					loss_thr_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// intake and classification
	lbse_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.arrival_time        (arrival_time),
		.packet_length       (packet_length),
		.ip_kind             (ip_kind),
		.ecn_bits            (ecn_bits),
		.loss_draw           (loss_draw),
		.delay_ticks         (delay_ticks_q),
		.ticks_per_byte_q16  (tpb_q),
		.backlog_bound_ticks (bound_q),
		.ecn_threshold_ticks (ecn_thr_q),
		.loss_threshold      (loss_thr_q),
		.fifo_count          (fifo_count),
		.push                (push),
		.push_entry          (push_entry)
	);

	// queue between front and back
	lbse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.empty      (fifo_empty),
		.count      (fifo_count)
	);

	// scheduling and result
	lbse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_entry  (head_entry),
		.fifo_empty  (fifo_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.mark_ce     (mark_ce),
		.depart_time (depart_time)
	);

endmodule

// ===== sim/leaky_bucket_shaper_ecn_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_bucket_shaper_ecn_tb: self-checking bench for the shaper
// Drives packets through the shaper and predicts every verdict, CE mark and
// send time from an independent model of the link's next-free time.
// Directed tests hit the threshold edges, ECN classes, loss bounds, time wrap
// and next-free saturation. Random traffic aims each packet's backlog at or
// near the thresholds under several register settings, with random gaps and
// back-pressure on both sides.
// ----------------------------------------------------------------------------
module leaky_bucket_shaper_ecn_tb;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 9;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 128;

	// header codes not named in the package
	localparam logic [1:0] IP_KIND_V4     = 2'd0;
	localparam logic [1:0] IP_KIND_V6     = 2'd1;
	localparam logic [1:0] IP_KIND_OTHER  = 2'd3;
	localparam logic [1:0] ECN_ECT1       = 2'd1;
	localparam logic [1:0] ECN_ECT0       = 2'd2;
	localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

	typedef struct packed {
		logic [47:0] arrival;
		logic [13:0] length;
		logic [1:0]  kind;
		logic [1:0]  ecn;
		logic [63:0] draw;
	} packet_t;

	typedef struct packed {
		lbse_pkg::verdict_t outcome;
		logic               mark;
		logic [47:0]        send;
	} result_t;

	typedef struct packed {
		logic [31:0] delay;
		logic [31:0] tpb;
		logic [31:0] bound;
		logic [31:0] ecn_thr;
		logic [63:0] loss_thr;
	} shaper_cfg_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [47:0] arrival_time  = '0;
	logic [13:0] packet_length = '0;
	logic [1:0]  ip_kind       = '0;
	logic [1:0]  ecn_bits      = '0;
	logic [63:0] loss_draw     = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [1:0]  verdict;
	logic        mark_ce;
	logic [47:0] depart_time;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [63:0] cfg_data      = '0;

	// shaper model: registers at their reset values, link free time in q16
	logic [31:0] delay_reg    = 32'd0;
	logic [31:0] tpb_reg      = 32'h0001_0000;
	logic [31:0] bound_reg    = 32'hFFFF_FFFF;
	logic [31:0] ecn_thr_reg  = 32'hFFFF_FFFF;
	logic [63:0] loss_thr_reg = 64'd0;
	logic [63:0] link_free_q  = 64'd0;

	result_t     pending_results[$];
	bit          tx_idle_on = 1'b1;
	bit          rx_stall_on = 1'b1;
	int unsigned rx_hold;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned packets_sent;
	int unsigned settings_applied;
	int unsigned marks_seen;
	int unsigned verdicts_seen[4];

	leaky_bucket_shaper_ecn i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.arrival_time  (arrival_time),
		.packet_length (packet_length),
		.ip_kind       (ip_kind),
		.ecn_bits      (ecn_bits),
		.loss_draw     (loss_draw),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.mark_ce       (mark_ce),
		.depart_time   (depart_time),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("leaky_bucket_shaper_ecn_tb: done, errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// schedule one packet against the link and advance the free time
	function automatic result_t shape_packet(input packet_t p);
		logic [47:0] nominal;
		logic [63:0] nominal_q;
		logic [63:0] sched_q;
		logic [63:0] backlog_q;
		logic [63:0] serial_q;
		logic [64:0] advanced_q;
		result_t     r;
		r.outcome = lbse_pkg::VERDICT_FORWARD;
		r.mark    = 1'b0;
		r.send    = '0;
		nominal   = p.arrival + 48'(delay_reg);
		nominal_q = {nominal, 16'h0000};
		sched_q   = (link_free_q > nominal_q) ? link_free_q : nominal_q;
		backlog_q = sched_q - nominal_q;
		// over the bound: dropped, link untouched
		if (backlog_q > {16'h0000, bound_reg, 16'h0000}) begin
			r.outcome = lbse_pkg::VERDICT_BACKLOG;
			return r;
		end
		// over the ecn threshold: mark capable traffic, drop the rest
		if (backlog_q > {16'h0000, ecn_thr_reg, 16'h0000}) begin
			if (p.kind >= lbse_pkg::IP_KIND_NOT_IP || p.ecn == lbse_pkg::ECN_NOT_ECT) begin
				r.outcome = lbse_pkg::VERDICT_NOT_ECT;
				return r;
			end
			r.mark = (p.ecn != lbse_pkg::ECN_CE);
		end
		// link busy for the wire time, saturating
		serial_q    = (64'(p.length) + 64'(lbse_pkg::OVERHEAD_BYTES)) * 64'(tpb_reg);
		advanced_q  = {1'b0, sched_q} + {1'b0, serial_q};
		link_free_q = advanced_q[64] ? '1 : advanced_q[63:0];
		if (p.draw < loss_thr_reg) begin
			r.outcome = lbse_pkg::VERDICT_LOSS;
			r.mark    = 1'b0;
			return r;
		end
		r.send = sched_q[63:16];
		return r;
	endfunction

	function automatic void apply_register(input logic [2:0] idx, input logic [63:0] data);
		case (idx)
			lbse_pkg::CFG_DELAY:    delay_reg    = data[31:0];
			lbse_pkg::CFG_TPB:      tpb_reg      = data[31:0];
			lbse_pkg::CFG_BOUND:    bound_reg    = data[31:0];
			lbse_pkg::CFG_ECN_THR:  ecn_thr_reg  = data[31:0];
			lbse_pkg::CFG_LOSS_THR: loss_thr_reg = data;
			default: ;
		endcase
	endfunction

	// arrival that lands the packet with the given backlog in ticks;
	// negative backlog means the link is idle that long before it arrives
	function automatic logic [47:0] arrival_for_backlog(input logic [47:0] backlog);
		logic [47:0] free_tick;
		free_tick = link_free_q[63:16];
		if (!backlog[47] && backlog > free_tick)
			backlog = free_tick;
		return free_tick - backlog - 48'(delay_reg);
	endfunction

	function automatic packet_t make_packet(input logic [47:0] arrival, input logic [13:0] length,
			input logic [1:0] kind, input logic [1:0] ecn, input logic [63:0] draw);
		packet_t p;
		p.arrival = arrival;
		p.length  = length;
		p.kind    = kind;
		p.ecn     = ecn;
		p.draw    = draw;
		return p;
	endfunction

	function automatic shaper_cfg_t make_cfg(input logic [31:0] delay, input logic [31:0] tpb,
			input logic [31:0] bound, input logic [31:0] ecn_thr, input logic [63:0] loss_thr);
		shaper_cfg_t s;
		s.delay    = delay;
		s.tpb      = tpb;
		s.bound    = bound;
		s.ecn_thr  = ecn_thr;
		s.loss_thr = loss_thr;
		return s;
	endfunction

	// random packet with its backlog aimed around the thresholds
	function automatic packet_t random_packet();
		packet_t     p;
		logic [47:0] backlog;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			backlog = -48'($urandom_range(0, 2000));
		else if (roll < 30)
			backlog = -48'($urandom);
		else if (roll < 45)
			backlog = 48'(ecn_thr_reg) + 48'($urandom_range(0, 2)) - 48'd1;
		else if (roll < 60)
			backlog = 48'(bound_reg) + 48'($urandom_range(0, 2)) - 48'd1;
		else if (roll < 80)
			backlog = 48'($urandom_range(0, ecn_thr_reg));
		else
			backlog = 48'($urandom_range(0, bound_reg));
		p.arrival = arrival_for_backlog(backlog);
		roll = $urandom_range(0, 99);
		if (roll < 70)
			p.length = 14'($urandom_range(0, 100));
		else if (roll < 95)
			p.length = 14'($urandom_range(0, 1500));
		else
			p.length = 14'($urandom);
		p.kind = 2'($urandom_range(0, 3));
		p.ecn  = 2'($urandom_range(0, 3));
		if (loss_thr_reg != 0 && $urandom_range(0, 9) < 3)
			p.draw = loss_thr_reg + 64'($urandom_range(0, 2)) - 64'd1;
		else
			p.draw = {$urandom, $urandom};
		return p;
	endfunction

	// present one item, hold it until taken, then maybe idle
	task automatic send_packet(input packet_t p);
		int unsigned gap;
		arrival_time  <= p.arrival;
		packet_length <= p.length;
		ip_kind       <= p.kind;
		ecn_bits      <= p.ecn;
		loss_draw     <= p.draw;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(shape_packet(p));
		packets_sent++;
		gap = (tx_idle_on && $urandom_range(0, 9) < 4) ? idle_cycles() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_beat(input logic [2:0] idx, input logic [63:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, data);
	endtask

	// write all registers back to back, junk in the unused upper bits
	task automatic program_shaper(input shaper_cfg_t s, input bit poke_unused);
		cfg_valid <= 1'b1;
		write_beat(lbse_pkg::CFG_DELAY, {$urandom, s.delay});
		write_beat(lbse_pkg::CFG_TPB, {$urandom, s.tpb});
		write_beat(lbse_pkg::CFG_BOUND, {$urandom, s.bound});
		write_beat(lbse_pkg::CFG_ECN_THR, {$urandom, s.ecn_thr});
		write_beat(lbse_pkg::CFG_LOSS_THR, s.loss_thr);
		if (poke_unused)
			write_beat(CFG_IDX_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// reset registers: one tick per byte, no delay, no limits, no loss
	task automatic test_reset_defaults();
		send_packet(make_packet('0, '0, IP_KIND_V4, lbse_pkg::ECN_NOT_ECT, '0));
		send_packet(make_packet('0, 14'h3FFF, IP_KIND_V6, lbse_pkg::ECN_CE, '1));
		send_packet(make_packet(arrival_for_backlog(-48'd5), 14'd60, lbse_pkg::IP_KIND_NOT_IP,
			ECN_ECT0, {$urandom, $urandom}));
		wait_for_results();
	endtask

	// backlog exactly at and one past each threshold, every ecn class
	task automatic test_ecn_marking();
		program_shaper(make_cfg(32'd100, 32'h0003_0000, 32'd1000, 32'd500, 64'd0), 1'b1);
		send_packet(make_packet(arrival_for_backlog(48'd500), 14'd64, IP_KIND_V4, ECN_ECT0, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, IP_KIND_V4, ECN_ECT0, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, IP_KIND_V6, ECN_ECT1, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, IP_KIND_V4,
			lbse_pkg::ECN_CE, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, IP_KIND_V4,
			lbse_pkg::ECN_NOT_ECT, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, lbse_pkg::IP_KIND_NOT_IP,
			ECN_ECT0, '0));
		send_packet(make_packet(arrival_for_backlog(48'd501), 14'd64, IP_KIND_OTHER, ECN_ECT1,
			'0));
		send_packet(make_packet(arrival_for_backlog(48'd1000), 14'd64, IP_KIND_V6, ECN_ECT0, '0));
		send_packet(make_packet(arrival_for_backlog(48'd1001), 14'd64, IP_KIND_V4, ECN_ECT0, '0));
		wait_for_results();
	endtask

	// draws on both sides of the loss threshold, then the all-ones threshold
	task automatic test_loss_threshold();
		logic [63:0] thr;
		thr = {1'b1, 31'($urandom), $urandom};
		program_shaper(make_cfg(32'd0, 32'h0001_0000, '1, '1, thr), 1'b0);
		send_packet(make_packet(arrival_for_backlog(-48'd10), 14'd40, IP_KIND_V4, ECN_ECT0,
			thr - 64'd1));
		send_packet(make_packet(arrival_for_backlog(-48'd10), 14'd40, IP_KIND_V4, ECN_ECT0, thr));
		send_packet(make_packet(arrival_for_backlog(-48'd10), 14'd40, IP_KIND_V4, ECN_ECT0,
			thr + 64'd1));
		wait_for_results();
		program_shaper(make_cfg(32'd0, 32'h0001_0000, '1, '1, '1), 1'b0);
		send_packet(make_packet(arrival_for_backlog(-48'd10), 14'd40, IP_KIND_V6, ECN_ECT1, '1));
		send_packet(make_packet(arrival_for_backlog(-48'd10), 14'd40, IP_KIND_V6, ECN_ECT1,
			64'hFFFF_FFFF_FFFF_FFFE));
		wait_for_results();
	endtask

	// nominal send time wraps past the top of the timestamp range
	task automatic test_time_wrap();
		program_shaper(make_cfg('1, 32'h0001_0000, '1, '1, 64'd0), 1'b0);
		send_packet(make_packet(48'hFFFF_FFFF_FFFB, 14'd0, IP_KIND_V4, ECN_ECT0, '0));
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		shaper_cfg_t s;
		int unsigned phase;
		int unsigned n;
		logic [31:0] bound;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			bound = $urandom_range(0, 32'h0001_0000);
			case (phase)
				0: s = make_cfg($urandom, $urandom_range(1, 32'h0004_0000),
					$urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0008_0000),
					{$urandom_range(0, 32'h2000_0000), $urandom});
				1: s = make_cfg(32'd0, 32'd1, 32'd0, 32'd0, 64'd0);
				2: s = make_cfg('1, '1, '1, '1, '1);
				3: s = make_cfg($urandom, $urandom_range(1, 32'h0010_0000), bound,
					bound + 32'($urandom_range(1, 1000)), 64'd0);
				default: s = make_cfg($urandom, $urandom_range(1, 32'hFFFF_FFFF), $urandom,
					$urandom, {$urandom_range(0, 32'h4000_0000), $urandom});
			endcase
			program_shaper(s, phase == 3);
			tx_idle_on  = phase[0];
			rx_stall_on = phase[1];
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// one pause mid-stream until the pipe is empty
				if (phase == 5 && n == ITEMS_PER_PHASE / 2)
					wait_for_results();
				send_packet(random_packet());
			end
			wait_for_results();
		end
		tx_idle_on  = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	// huge wire time at the last tick pins the free time at all ones
	task automatic test_link_saturation();
		program_shaper(make_cfg(32'd0, '1, '1, 32'd0, 64'd0), 1'b0);
		send_packet(make_packet('1, 14'h3FFF, IP_KIND_V4, ECN_ECT1, '0));
		send_packet(make_packet('1, 14'd100, IP_KIND_V4, ECN_ECT0, '0));
		send_packet(make_packet('1, 14'd100, IP_KIND_V6, lbse_pkg::ECN_CE, '0));
		wait_for_results();
	endtask

	// receiver back-pressure: alternating stall and free runs
	always @(posedge clk) begin
		if (rx_hold != 0)
			rx_hold--;
		else if (!rx_stall_on)
			out_stall <= 1'b0;
		else if (!out_stall) begin
			out_stall <= 1'b1;
			rx_hold = idle_cycles() - 1;
		end else begin
			out_stall <= 1'b0;
			rx_hold = $urandom_range(0, 12);
		end
	end

	// compare each delivered item with the oldest prediction
	always @(posedge clk) begin : check_result
		result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got verdict %0d depart_time %0h",
					$time, verdict, depart_time);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (verdict !== want.outcome) begin
					$display("%0t: verdict mismatch, expected %0d, got %0d",
						$time, want.outcome, verdict);
					mismatch_count++;
				end
				if (mark_ce !== want.mark) begin
					$display("%0t: mark_ce mismatch, expected %0b, got %0b",
						$time, want.mark, mark_ce);
					mismatch_count++;
				end
				if (depart_time !== want.send) begin
					$display("%0t: depart_time mismatch, expected %0h, got %0h",
						$time, want.send, depart_time);
					mismatch_count++;
				end
				verdicts_seen[want.outcome]++;
				if (want.mark)
					marks_seen++;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_ecn_marking();
		test_loss_threshold();
		test_time_wrap();
		test_random_traffic();
		test_link_saturation();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("shaped %0d packets under %0d register settings: %0d forwarded, %0d CE-marked",
			packets_sent, settings_applied, verdicts_seen[lbse_pkg::VERDICT_FORWARD], marks_seen);
		$display("drops: %0d backlog, %0d not ECN capable, %0d loss; %0d mismatches",
			verdicts_seen[lbse_pkg::VERDICT_BACKLOG], verdicts_seen[lbse_pkg::VERDICT_NOT_ECT],
			verdicts_seen[lbse_pkg::VERDICT_LOSS], mismatch_count);
		if (mismatch_count == 0)
			$display("leaky_bucket_shaper_ecn_tb: done, clean");
		else
			$display("leaky_bucket_shaper_ecn_tb: done, errors");
		$finish;
	end

endmodule
